// File: src/sli_pkg.sv
// Package: shared constants, codes and types of the sorted list intersection block.
`default_nettype none
package sli_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_LOAD_A,
        ST_SCAN,
        ST_HIT,
        ST_NEXT_A,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: src/sli_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module sli_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/sorted_list_intersection.sv
// Top level: list stores, compare sequencer and output register of the intersection block.
// Usage:
//   Input channel s_*: tuser carries func, tdata the value. Func 0 appends the
//   value to list A, func 1 to list B, func 2 computes; func 3 is ignored.
//   A load gives no word. A load into a full list is dropped and sets the
//   overflow flag.
//   Output channel m_*: one word per element of A found in B, walking A from
//   its last entry to its first; tlast marks the final word. With no match a
//   single word with the empty flag set and tdata zero is sent.
//   Throughput: one shared 32-bit comparator walks B for each entry of A,
//   one compare per cycle, stopping at the first match; s_tready stays low
//   from the accepting edge until the final word has been registered.
//   The sequencer holds one found element back until the next is found so
//   that the last word can be flagged.
//   A stall on m_tready holds the sequencer at its next emit point.
//   Reset clears counts, flags and the output valid; the list stores need
//   no clearing since only entries below each count are read. After a compute
//   both lists and the overflow flag are empty again.
`default_nettype none
module sorted_list_intersection (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic [1:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // common_value
    output logic             m_tlast,
    output logic      [1:0]  m_tuser    // empty_res, overflow
);

    localparam int CNT_W   = sli_pkg::CNT_W;
    localparam int ADDR_W  = sli_pkg::ADDR_W;
    localparam int VALUE_W = sli_pkg::VALUE_W;

    sli_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_a_reg, count_a_next;
    logic [CNT_W-1:0]   count_b_reg, count_b_next;
    logic               dropped_reg, dropped_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [VALUE_W-1:0] a_val_reg, a_val_next;
    logic [VALUE_W-1:0] pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               we_a, we_b;
    logic [ADDR_W-1:0]  b_raddr;
    logic [VALUE_W-1:0] a_rdata, b_rdata;
    logic               accept;
    logic               out_free;
    logic               j_at_end;
    sli_pkg::func_t     func;

    assign func     = sli_pkg::func_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign j_at_end = {{(CNT_W-ADDR_W){1'b0}}, j_reg} == (count_b_reg - {{(CNT_W-1){1'b0}}, 1'b1});

    sli_ram #(.WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (i_reg),
        .rdata (a_rdata)
    );

    sli_ram #(.WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sli_pkg::ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        a_val_reg     <= a_val_next;
        pend_reg      <= pend_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        dropped_next    = dropped_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_val_next      = a_val_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        s_tready        = 1'b0;
        we_a            = 1'b0;
        we_b            = 1'b0;
        b_raddr         = j_reg + {{(ADDR_W-1){1'b0}}, 1'b1};

        case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    case (func)
                        sli_pkg::FUNC_LOAD_A:
                        begin
                            if (count_a_reg >= CNT_W'(sli_pkg::CAPACITY))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                we_a         = 1'b1;
                                count_a_next = count_a_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        sli_pkg::FUNC_LOAD_B:
                        begin
                            if (count_b_reg >= CNT_W'(sli_pkg::CAPACITY))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                we_b         = 1'b1;
                                count_b_next = count_b_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        sli_pkg::FUNC_COMPUTE:
                        begin
                            pend_valid_next = 1'b0;
                            if (count_a_reg == '0)
                            begin
                                state_next = sli_pkg::ST_FINISH;
                            end
                            else
                            begin
                                i_next     = ADDR_W'(count_a_reg - {{(CNT_W-1){1'b0}}, 1'b1});
                                state_next = sli_pkg::ST_FETCH_A;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            sli_pkg::ST_FETCH_A:
            begin
                state_next = sli_pkg::ST_LOAD_A;
            end

            sli_pkg::ST_LOAD_A:
            begin
                a_val_next = a_rdata;
                j_next     = '0;
                b_raddr    = '0;
                state_next = (count_b_reg == '0) ? sli_pkg::ST_NEXT_A : sli_pkg::ST_SCAN;
            end

            sli_pkg::ST_SCAN:
            begin
                if (b_rdata == a_val_reg)
                begin
                    state_next = sli_pkg::ST_HIT;
                end
                else if (j_at_end)
                begin
                    state_next = sli_pkg::ST_NEXT_A;
                end
                else
                begin
                    j_next = j_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                end
            end

            sli_pkg::ST_HIT:
            begin
                if (!pend_valid_reg)
                begin
                    pend_next       = a_val_reg;
                    pend_valid_next = 1'b1;
                    state_next      = sli_pkg::ST_NEXT_A;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    out_last_next  = 1'b0;
                    out_empty_next = 1'b0;
                    out_ovf_next   = dropped_reg;
                    pend_next      = a_val_reg;
                    state_next     = sli_pkg::ST_NEXT_A;
                end
            end

            sli_pkg::ST_NEXT_A:
            begin
                if (i_reg == '0)
                begin
                    state_next = sli_pkg::ST_FINISH;
                end
                else
                begin
                    i_next     = i_reg - {{(ADDR_W-1){1'b0}}, 1'b1};
                    state_next = sli_pkg::ST_FETCH_A;
                end
            end

            sli_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = pend_valid_reg ? pend_reg : '0;
                    out_last_next   = 1'b1;
                    out_empty_next  = !pend_valid_reg;
                    out_ovf_next    = dropped_reg;
                    pend_valid_next = 1'b0;
                    count_a_next    = '0;
                    count_b_next    = '0;
                    dropped_next    = 1'b0;
                    state_next      = sli_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sli_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

`ifndef SYNTHESIS
    a_count_a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(sli_pkg::CAPACITY))
        else $error("list A count above capacity");

    a_count_b_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_b_reg <= CNT_W'(sli_pkg::CAPACITY))
        else $error("list B count above capacity");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == '0))
        else $error("empty word without tlast or with nonzero data");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sli_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("held element left over in idle");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench: stream-level check of the sorted list intersection block against a local predictor.
`timescale 1ns / 100ps
module tb_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 120;

    typedef struct packed {
        logic [31:0] common_value;
        logic        last;
        logic        empty_res;
        logic        overflow;
    } common_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = sli_pkg::FUNC_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // predictor state
    logic [31:0]  list_a[$];
    logic [31:0]  list_b[$];
    logic         list_dropped = 1'b0;
    common_word_t pending_common[$];
    common_word_t want;

    int error_count = 0;
    int cycle_count = 0;
    int rx_hold_cycles = 0;
    int rx_stall_left = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    sorted_list_intersection u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_list_intersection test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
        error_count++;
    endtask

    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic void predict_word(input sli_pkg::func_t f, input logic [31:0] v);
        logic [31:0]  hits[$];
        common_word_t w;
        logic         hit;
        case (f)
            sli_pkg::FUNC_LOAD_A:
                if (list_a.size() < sli_pkg::CAPACITY) list_a.push_back(v);
                else list_dropped = 1'b1;
            sli_pkg::FUNC_LOAD_B:
                if (list_b.size() < sli_pkg::CAPACITY) list_b.push_back(v);
                else list_dropped = 1'b1;
            sli_pkg::FUNC_COMPUTE:
            begin
                for (int i = list_a.size() - 1; i >= 0; i--)
                begin
                    hit = 1'b0;
                    foreach (list_b[j])
                        if (list_b[j] == list_a[i]) hit = 1'b1;
                    if (hit) hits.push_back(list_a[i]);
                end
                if (hits.size() == 0)
                begin
                    w = '{common_value: '0, last: 1'b1, empty_res: 1'b1,
                          overflow: list_dropped};
                    pending_common.push_back(w);
                end
                foreach (hits[k])
                begin
                    w = '{common_value: hits[k], last: (k == hits.size() - 1),
                          empty_res: 1'b0, overflow: list_dropped};
                    pending_common.push_back(w);
                end
                list_a = {};
                list_b = {};
                list_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that accepts the word
    task automatic send_word(input sli_pkg::func_t f, input logic [31:0] v);
        int gap;
        gap = (tx_steady || $urandom_range(0, 1)) ? 0 : stall_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        predict_word(f, v);
    endtask

    // sender idles until every expected word has come
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_common.size() != 0);
    endtask

    function automatic logic [31:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'h7FFF_FFF8;
        if (r < 20) return 32'h8000_0000;
        if (r < 30) return 32'($urandom_range(0, 16)) - 32'd8;
        return $urandom;
    endfunction

    function automatic void make_list(output logic [31:0] vals[$], input int n,
                                      input logic [31:0] start, input bit noise);
        logic [31:0] cur;
        logic [31:0] nxt;
        vals = {};
        cur = start;
        for (int i = 0; i < n; i++)
        begin
            if (noise)
                vals.push_back($urandom_range(0, 3) == 0 ? $urandom
                                                         : start + $urandom_range(0, 15));
            else
            begin
                vals.push_back(cur);
                nxt = cur + $urandom_range(0, 3);
                if ($signed(nxt) >= $signed(cur)) cur = nxt;
            end
        end
    endfunction

    task automatic send_lists(input logic [31:0] a_vals[$], input logic [31:0] b_vals[$],
                              input bit noise);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < a_vals.size() || ib < b_vals.size())
        begin
            if (noise && $urandom_range(0, 5) == 0) send_word(sli_pkg::FUNC_NONE, $urandom);
            if (ib >= b_vals.size() || (ia < a_vals.size() && $urandom_range(0, 1)))
            begin
                send_word(sli_pkg::FUNC_LOAD_A, a_vals[ia]);
                ia++;
            end
            else
            begin
                send_word(sli_pkg::FUNC_LOAD_B, b_vals[ib]);
                ib++;
            end
        end
    endtask

    task automatic test_directed();
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
        send_word(sli_pkg::FUNC_LOAD_A, 32'h8000_0000);
        send_word(sli_pkg::FUNC_LOAD_A, 32'hFFFF_FFFF);
        send_word(sli_pkg::FUNC_LOAD_A, 32'h0000_0000);
        send_word(sli_pkg::FUNC_NONE, 32'hFFFF_FFFF);
        send_word(sli_pkg::FUNC_LOAD_A, 32'h0000_0001);
        send_word(sli_pkg::FUNC_LOAD_A, 32'h7FFF_FFFF);
        send_word(sli_pkg::FUNC_LOAD_B, 32'h8000_0000);
        send_word(sli_pkg::FUNC_LOAD_B, 32'h0000_0000);
        send_word(sli_pkg::FUNC_LOAD_B, 32'h7FFF_FFFF);
        send_word(sli_pkg::FUNC_COMPUTE, 32'hFFFF_FFFF);
        // duplicates in A come out once per copy
        send_word(sli_pkg::FUNC_LOAD_A, 32'd5);
        send_word(sli_pkg::FUNC_LOAD_A, 32'd5);
        send_word(sli_pkg::FUNC_LOAD_A, 32'd7);
        send_word(sli_pkg::FUNC_LOAD_B, 32'd5);
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
        // unsorted lists, duplicates in B
        send_word(sli_pkg::FUNC_LOAD_A, 32'd9);
        send_word(sli_pkg::FUNC_LOAD_A, 32'd2);
        send_word(sli_pkg::FUNC_LOAD_A, 32'd4);
        send_word(sli_pkg::FUNC_LOAD_B, 32'd4);
        send_word(sli_pkg::FUNC_LOAD_B, 32'd9);
        send_word(sli_pkg::FUNC_LOAD_B, 32'd9);
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
        // no common element
        send_word(sli_pkg::FUNC_LOAD_A, 32'd1);
        send_word(sli_pkg::FUNC_LOAD_B, 32'd2);
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
    endtask

    task automatic test_capacity();
        for (int i = 0; i < sli_pkg::CAPACITY + 2; i++)
            send_word(sli_pkg::FUNC_LOAD_A, 32'(2 * i));
        for (int i = 0; i < sli_pkg::CAPACITY + 2; i++)
            send_word(sli_pkg::FUNC_LOAD_B, 32'(3 * i));
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
        // overflow flag on an empty result, then cleared by the compute
        send_word(sli_pkg::FUNC_LOAD_A, 32'd1);
        for (int i = 0; i < sli_pkg::CAPACITY + 1; i++)
            send_word(sli_pkg::FUNC_LOAD_B, 32'(1000 + i));
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
        send_word(sli_pkg::FUNC_COMPUTE, 32'h0);
    endtask

    task automatic test_backpressure();
        logic [31:0] a_vals[$];
        logic [31:0] b_vals[$];
        rx_hold_cycles = 400;
        repeat (3)
        begin
            make_list(a_vals, 6, 32'd100, 1'b0);
            make_list(b_vals, 6, 32'd101, 1'b0);
            send_lists(a_vals, b_vals, 1'b0);
            send_word(sli_pkg::FUNC_COMPUTE, $urandom);
        end
        wait_drain();
        make_list(a_vals, 8, 32'hFFFF_FFFC, 1'b0);
        make_list(b_vals, 8, 32'hFFFF_FFFD, 1'b0);
        send_lists(a_vals, b_vals, 1'b0);
        send_word(sli_pkg::FUNC_COMPUTE, $urandom);
        wait_drain();
    endtask

    task automatic test_random();
        logic [31:0] a_vals[$];
        logic [31:0] b_vals[$];
        logic [31:0] start;
        int          sent;
        int          na;
        int          nb;
        int          r;
        bit          noise;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
            begin
                na = $urandom_range(0, 8);
                nb = $urandom_range(0, 8);
            end
            else if (r < 97)
            begin
                na = $urandom_range(9, 24);
                nb = $urandom_range(9, 24);
            end
            else
            begin
                na = $urandom_range(60, 70);
                nb = $urandom_range(60, 70);
            end
            noise = ($urandom_range(0, 99) < 15);
            start = pick_start();
            make_list(a_vals, na, start, noise);
            make_list(b_vals, nb, start + $urandom_range(0, 3), noise);
            tx_steady = ($urandom_range(0, 9) == 0);
            rx_steady = ($urandom_range(0, 9) == 0);
            send_lists(a_vals, b_vals, noise);
            send_word(sli_pkg::FUNC_COMPUTE, $urandom);
            sent += na + nb + 1;
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
    endtask

    // result sink with random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 25)
            begin
                rx_stall_left = stall_length() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_common.size() == 0)
                report_mismatch("word with nothing pending", m_tdata, 32'h0);
            else
            begin
                want = pending_common.pop_front();
                if (m_tdata !== want.common_value)
                    report_mismatch("common_value", m_tdata, want.common_value);
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                if (m_tuser[0] !== want.empty_res)
                    report_mismatch("empty_res", 32'(m_tuser[0]), 32'(want.empty_res));
                if (m_tuser[1] !== want.overflow)
                    report_mismatch("overflow", 32'(m_tuser[1]), 32'(want.overflow));
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        wait_drain();
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_common.size() == 0)
            $display("sorted_list_intersection test passed");
        else
            $display("sorted_list_intersection test failed");
        $finish;
    end

endmodule
